>>> sv/thab_pkg.sv
// Shared types, constants and a helper function for the text and halo alpha blender.
package thab_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned WeightW   = 7;
    localparam int unsigned LaneW     = 8;
    localparam int unsigned ProdW     = 2 * LaneW;
    localparam int unsigned SumW      = ProdW + 2;
    localparam int unsigned NumLanes  = 4;
    localparam int unsigned ColorW    = 24;
    localparam int unsigned CfgIndexW = 2;

    localparam logic [WeightW-1:0] FULL_WEIGHT  = 7'd64;
    localparam logic [LaneW-1:0]   PAIR_WEIGHT  = 8'd128;
    localparam int unsigned        LUMA_SHIFT   = 6;
    localparam int unsigned        CHROMA_SHIFT = 7;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_PIXEL_MODE = 2'd0,
        REG_TEXT_COLOR = 2'd1,
        REG_HALO_COLOR = 2'd2
    } cfg_reg_t;

    localparam logic [ColorW-1:0] TEXT_COLOR_RESET = 24'hFFFF00;
    localparam logic [ColorW-1:0] HALO_COLOR_RESET = 24'h000000;

    // Operands of one lane after weight clamping and mode steering.
    typedef struct packed {
        logic [LaneW-1:0] pix;
        logic [LaneW-1:0] c_text;
        logic [LaneW-1:0] c_halo;
        logic [LaneW-1:0] w_pix;
        logic [LaneW-1:0] w_text;
        logic [LaneW-1:0] w_halo;
        logic             chroma;
    } lane_op_t;

    // Partial products of one lane.
    typedef struct packed {
        logic [ProdW-1:0] p_pix;
        logic [ProdW-1:0] p_text;
        logic [ProdW-1:0] p_halo;
        logic             chroma;
    } lane_prod_t;

    // Clamped weight pair of one pixel.
    typedef struct packed {
        logic [WeightW-1:0] t;
        logic [WeightW-1:0] h;
    } weight_pair_t;

    function automatic weight_pair_t clamp_weights(input logic [WeightW-1:0] t_in,
                                                   input logic [WeightW-1:0] h_in);
        weight_pair_t       r;
        logic [WeightW-1:0] room;
        r.t  = (t_in > FULL_WEIGHT) ? FULL_WEIGHT : t_in;
        room = FULL_WEIGHT - r.t;
        r.h  = (h_in > room) ? room : h_in;
        return r;
    endfunction

endpackage

>>> sv/text_halo_alpha_blend.sv
// Top level of the text and halo alpha blender: a three-stage pixel pipeline.
//
// The blender takes one word per clock and returns one blended word per clock
// once the pipeline is full and while the output side does not stall. An
// accepted word passes through the stage one, stage two and output registers
// in that order and leaves from the output register. Stage one
// clamps the coverage weights (text to 64, halo to 64 minus text) and steers
// the bytes, colors and weights of each of the four byte lanes according to
// pixel_mode. Stage two forms the three 8x8 products of each lane. Stage three
// adds them, shifts by 6 (luma and RGB) or 7 (YUY2 chroma) and holds the word
// in the output register. Each stage keeps its own valid bit and loads whenever
// the stage after it is empty or is being emptied, so a stall on the output
// side fills the bubbles first and never drops or repeats a word; s_tready
// falls only when all three stages are full and the output is stalled. In RGB
// mode byte 3 passes through by blending it with a pixel weight of 64 and no
// color weight. Configuration is sampled in stage one and must only be written
// while the pipeline is empty.
module text_halo_alpha_blend (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input word. tdata from bit 0: in_byte0, in_byte1, in_byte2, in_byte3,
    // text_weight0, halo_weight0, text_weight1, halo_weight1, 4 zero bits.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,
    // Output word. tdata from bit 0: out_byte0, out_byte1, out_byte2, out_byte3.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [thab_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [23:0]                    cfg_data
);
    import thab_pkg::*;

    // Configuration registers.
    logic              pixel_mode_reg;
    logic [ColorW-1:0] text_color_reg;
    logic [ColorW-1:0] halo_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg <= 1'b0;
            text_color_reg <= TEXT_COLOR_RESET;
            halo_color_reg <= HALO_COLOR_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CfgIndexW'(REG_PIXEL_MODE))
                pixel_mode_reg <= cfg_data[0];
            if (cfg_index == CfgIndexW'(REG_TEXT_COLOR))
                text_color_reg <= cfg_data;
            if (cfg_index == CfgIndexW'(REG_HALO_COLOR))
                halo_color_reg <= cfg_data;
        end
    end

    // Unpack the input word.
    logic [ByteW-1:0]   in_byte   [NumLanes];
    logic [WeightW-1:0] text_w0, halo_w0, text_w1, halo_w1;

    always_comb
    begin
        for (int i = 0; i < NumLanes; i++)
            in_byte[i] = s_tdata[i*ByteW +: ByteW];
        text_w0 = s_tdata[32 +: WeightW];
        halo_w0 = s_tdata[39 +: WeightW];
        text_w1 = s_tdata[46 +: WeightW];
        halo_w1 = s_tdata[53 +: WeightW];
    end

    // Valid bits and the stall chain.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_load, s2_load, s3_load;

    assign s3_load  = !s3_valid_reg || m_tready;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign s_tready = s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= s_tvalid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
            if (s3_load)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage one: clamp the weights and steer operands to the lanes.
    weight_pair_t     wp0, wp1;
    logic [LaneW-1:0] t_sum, h_sum;
    lane_op_t         s1_next [NumLanes];
    lane_op_t         s1_reg  [NumLanes];

    function automatic lane_op_t make_lane(input logic [LaneW-1:0] pix,
                                           input logic [LaneW-1:0] ct,
                                           input logic [LaneW-1:0] ch,
                                           input logic [LaneW-1:0] wt,
                                           input logic [LaneW-1:0] wh,
                                           input logic             chroma);
        lane_op_t         r;
        logic [LaneW-1:0] total;
        total    = chroma ? PAIR_WEIGHT : LaneW'(FULL_WEIGHT);
        r.pix    = pix;
        r.c_text = ct;
        r.c_halo = ch;
        r.w_text = wt;
        r.w_halo = wh;
        r.w_pix  = total - wt - wh;
        r.chroma = chroma;
        return r;
    endfunction

    always_comb
    begin
        wp0   = clamp_weights(text_w0, halo_w0);
        wp1   = clamp_weights(text_w1, halo_w1);
        t_sum = LaneW'(wp0.t) + LaneW'(wp1.t);
        h_sum = LaneW'(wp0.h) + LaneW'(wp1.h);
        if (!pixel_mode_reg)
        begin
            // Packed RGB: B, G, R blend with their own color channel.
            for (int i = 0; i < 3; i++)
                s1_next[i] = make_lane(in_byte[i], text_color_reg[i*ByteW +: ByteW],
                                       halo_color_reg[i*ByteW +: ByteW],
                                       LaneW'(wp0.t), LaneW'(wp0.h), 1'b0);
            // Byte 3 passes through: full pixel weight and no color weight.
            s1_next[3] = make_lane(in_byte[3], '0, '0, '0, '0, 1'b0);
        end
        else
        begin
            // YUY2 pair: both luma bytes take the Y channel with their own
            // weights, the chroma bytes take the summed weights.
            s1_next[0] = make_lane(in_byte[0], text_color_reg[23:16], halo_color_reg[23:16],
                                   LaneW'(wp0.t), LaneW'(wp0.h), 1'b0);
            s1_next[1] = make_lane(in_byte[1], text_color_reg[15:8], halo_color_reg[15:8],
                                   t_sum, h_sum, 1'b1);
            s1_next[2] = make_lane(in_byte[2], text_color_reg[23:16], halo_color_reg[23:16],
                                   LaneW'(wp1.t), LaneW'(wp1.h), 1'b0);
            s1_next[3] = make_lane(in_byte[3], text_color_reg[7:0], halo_color_reg[7:0],
                                   t_sum, h_sum, 1'b1);
        end
    end

    // Stage two: the three products of each lane.
    lane_prod_t s2_next [NumLanes];
    lane_prod_t s2_reg  [NumLanes];

    always_comb
    begin
        for (int i = 0; i < NumLanes; i++)
        begin
            s2_next[i].p_pix  = ProdW'(s1_reg[i].pix)    * ProdW'(s1_reg[i].w_pix);
            s2_next[i].p_text = ProdW'(s1_reg[i].c_text) * ProdW'(s1_reg[i].w_text);
            s2_next[i].p_halo = ProdW'(s1_reg[i].c_halo) * ProdW'(s1_reg[i].w_halo);
            s2_next[i].chroma = s1_reg[i].chroma;
        end
    end

    // Stage three: sum, scale and hold for the output side.
    logic [SumW-1:0]  lane_sum [NumLanes];
    logic [ByteW-1:0] s3_next  [NumLanes];
    logic [ByteW-1:0] s3_reg   [NumLanes];

    always_comb
    begin
        for (int i = 0; i < NumLanes; i++)
        begin
            lane_sum[i] = SumW'(s2_reg[i].p_pix) + SumW'(s2_reg[i].p_text)
                        + SumW'(s2_reg[i].p_halo);
            s3_next[i]  = s2_reg[i].chroma ? lane_sum[i][CHROMA_SHIFT +: ByteW]
                                           : lane_sum[i][LUMA_SHIFT +: ByteW];
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_reg <= s1_next;
        if (s2_load)
            s2_reg <= s2_next;
        if (s3_load)
            s3_reg <= s3_next;
    end

    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = {s3_reg[3], s3_reg[2], s3_reg[1], s3_reg[0]};

    // Input may only stall when every stage holds a word and the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && !m_tready))
        else $error("input stalled while the pipeline had room");

    // A word in stage two is never overwritten while the output stalls behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_valid_reg && !m_tready) |=> s2_valid_reg)
        else $error("stage two word lost during an output stall");

    // The steered weights of lanes zero and one add up to the lane's total weight.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |->
            ((s1_reg[1].w_pix + s1_reg[1].w_text + s1_reg[1].w_halo)
                 == (s1_reg[1].chroma ? PAIR_WEIGHT : LaneW'(FULL_WEIGHT)))
            && ((s1_reg[0].w_pix + s1_reg[0].w_text + s1_reg[0].w_halo)
                 == LaneW'(FULL_WEIGHT)))
        else $error("lane weights do not add up to the full weight");

endmodule
